[hw/rtl/fys_pkg.sv]
// Shared types and constants for the Fisher-Yates shuffler.
package fys_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int ELEM_W        = 8;
    localparam int IDX_W         = 6;
    localparam int COUNT_W       = 7;
    localparam int RAND_W        = 32;
    localparam int POS_OUT_W     = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd28;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  index;
        logic [ELEM_W-1:0] element;
        logic [RAND_W-1:0] random_word;
    } cmd_t;

    typedef struct packed {
        logic [ELEM_W-1:0]    read_element;
        logic [POS_OUT_W-1:0] step_position;
        logic [POS_OUT_W-1:0] chosen_position;
        logic                 shuffle_done;
    } rsp_t;

endpackage

[hw/rtl/fisher_yates_shuffler.sv]
// Fisher-Yates shuffler top level: entry store, modulo unit and swap sequencer.
// One command item is worked at a time; cmd_stall is high from acceptance until the
// result has been moved into the output register. A load, an unknown op or a finished
// step goes straight to the result state; a read waits for the read data. A swapping
// step works out the bit-serial remainder of random_word by (position+1), then read,
// read and two writes through the store's single write port. The result register
// lets the next item in while the previous result still waits on rsp_stall. The store
// is not cleared at reset; entries must be loaded before they are read or shuffled.
module fisher_yates_shuffler #(
    parameter int MAX_ITEMS = fys_pkg::MAX_ITEMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  fys_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fys_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fys_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int PW  = $clog2(MAX_ITEMS);
    localparam int DW  = PW + 1;
    localparam int CNW = $clog2(fys_pkg::RAND_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_DIV,
        S_SWAP_RD,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_RESP
    } state_t;

    // Saturate the count into 2..MAX_ITEMS and give the starting position.
    function automatic logic [PW-1:0] start_pos(input logic [fys_pkg::COUNT_W-1:0] c);
        logic [PW-1:0] r;
        if (c < 2)
            r = PW'(1);
        else if (int'(c) > MAX_ITEMS)
            r = PW'(MAX_ITEMS - 1);
        else
            r = PW'(c - 1'b1);
        return r;
    endfunction

    state_t                       state_reg, state_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [PW-1:0]                restart_reg, restart_next;
    logic [fys_pkg::RAND_W-1:0]   dvd_reg, dvd_next;
    logic [DW-1:0]                rem_reg, rem_next;
    logic [DW-1:0]                dvs_reg, dvs_next;
    logic [CNW-1:0]               cnt_reg, cnt_next;
    logic [fys_pkg::ELEM_W-1:0]   vp_reg, vp_next;
    fys_pkg::rsp_t                res_reg, res_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    fys_pkg::rsp_t                rsp_reg, rsp_next;

    logic                         ram_we;
    logic [PW-1:0]                ram_waddr;
    logic [fys_pkg::ELEM_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [PW-1:0]                ram_raddr;
    logic [fys_pkg::ELEM_W-1:0]   ram_rdata;

    logic                         cmd_acc;
    logic                         idx_ok;
    logic [DW:0]                  trial;
    logic [PW-1:0]                chosen;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd_valid && (state_reg == S_IDLE);
    assign idx_ok    = int'(cmd.index) < MAX_ITEMS;
    assign trial     = {rem_reg, dvd_reg[fys_pkg::RAND_W-1]};
    assign chosen    = PW'(rem_reg);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    fys_ram #(
        .WIDTH (fys_pkg::ELEM_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        restart_next   = restart_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        vp_next        = vp_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    restart_next = start_pos(cfg_data);
                    pos_next     = start_pos(cfg_data);
                end
                if (cmd_acc)
                begin
                    res_next = '0;
                    case (cmd.op)
                        fys_pkg::OP_LOAD:
                        begin
                            ram_we    = idx_ok;
                            ram_waddr = PW'(cmd.index);
                            ram_wdata = cmd.element;
                            pos_next  = restart_reg;
                            res_next.shuffle_done = (restart_reg == '0);
                            state_next = S_RESP;
                        end
                        fys_pkg::OP_STEP:
                        begin
                            if (pos_reg == '0)
                            begin
                                res_next.shuffle_done = 1'b1;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // fetch entry[p] while the remainder is worked out
                                ram_re    = 1'b1;
                                ram_raddr = pos_reg;
                                dvd_next  = cmd.random_word;
                                rem_next  = '0;
                                dvs_next  = DW'(pos_reg) + 1'b1;
                                cnt_next  = '0;
                                state_next = S_DIV;
                            end
                        end
                        fys_pkg::OP_READ:
                        begin
                            res_next.shuffle_done = (pos_reg == '0);
                            if (idx_ok)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = PW'(cmd.index);
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            res_next.shuffle_done = (pos_reg == '0);
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                res_next.read_element = ram_rdata;
                state_next = S_RESP;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, dvs_reg})
                    rem_next = DW'(trial - {1'b0, dvs_reg});
                else
                    rem_next = DW'(trial);
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNW'(fys_pkg::RAND_W - 1))
                    state_next = S_SWAP_RD;
            end
            S_SWAP_RD:
            begin
                vp_next   = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = chosen;
                state_next = S_SWAP_WR1;
            end
            S_SWAP_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                state_next = S_SWAP_WR2;
            end
            S_SWAP_WR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = chosen;
                ram_wdata = vp_reg;
                res_next.step_position   = fys_pkg::POS_OUT_W'(pos_reg);
                res_next.chosen_position = fys_pkg::POS_OUT_W'(chosen);
                res_next.shuffle_done    = (pos_reg == PW'(1));
                pos_next  = pos_reg - 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= start_pos(fys_pkg::COUNT_RESET);
            restart_reg   <= start_pos(fys_pkg::COUNT_RESET);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            restart_reg   <= restart_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        vp_reg  <= vp_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

[hw/rtl/fys_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read data.
module fys_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fys_checker.sv]
// Port-level checks for the Fisher-Yates shuffler, bound to the top level.
module fys_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_stall,
    input fys_pkg::cmd_t               cmd,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input fys_pkg::rsp_t               rsp,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [fys_pkg::COUNT_W-1:0] cfg_data
);

    // a stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // one item at a time: the block stalls right after taking one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second item taken while one is in flight");

    // a result with a nonzero read element never carries swap positions
    a_read_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_element != '0) |->
            (rsp.step_position == '0) && (rsp.chosen_position == '0))
        else $error("read result carries swap positions");

    // a stalled command item holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command item changed while stalled");

    // register writes carry known data
    a_cfg_data_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !$isunknown(cfg_data))
        else $error("register write with unknown data");

endmodule

bind fisher_yates_shuffler fys_checker u_fys_checker (.*);
